FILE: rtl/core/clipped_sprite_blitter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped sprite blitter
// Shared wrappers so every check uses the same clock, reset and report form.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_SPRITE_BLITTER_MACROS_SVH
`define CLIPPED_SPRITE_BLITTER_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define CSB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define CSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/csb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pkg
// Types, field widths, register indexes and reset values of the clipped
// sprite blitter.
// ----------------------------------------------------------------------------
package csb_pkg;

   // Field widths
   localparam int COLOR_W     = 32;
   localparam int DST_ADDR_W  = 17;
   localparam int POS_W       = 12;
   localparam int SIZE_W      = 10;
   localparam int TEX_W       = 12;
   localparam int STRIDE_W    = 13;
   localparam int FLIP_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Internal widths of the clip math
   localparam int CLIP_W      = 14;  // signed edge arithmetic
   localparam int POS_U_W     = 11;  // clipped start column / row, 0..2047
   localparam int COORD_W     = 13;  // texture column / row, 0..5118
   localparam int SPAN_W      = 10;
   localparam int VIEW_W      = 12;  // view size up to 2048

   localparam logic [COLOR_W-1:0] ALPHA_MASK = 32'hff00_0000;

   // Reset values of the configuration registers
   localparam logic [SIZE_W-1:0]   SPRITE_SIZE_RST = 10'd16;
   localparam logic [STRIDE_W-1:0] SRC_STRIDE_RST  = 13'd320;

   // Flip bits
   localparam int FLIP_H_BIT = 0;
   localparam int FLIP_V_BIT = 1;

   typedef enum logic {
      OP_START = 1'b0,
      OP_PIXEL = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X        = 3'd0,
      REG_DEST_Y        = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_TEX_X         = 3'd4,
      REG_TEX_Y         = 3'd5,
      REG_SRC_STRIDE    = 3'd6,
      REG_FLIP_MODE     = 3'd7
   } csr_index_type;

endpackage

FILE: rtl/core/clipped_sprite_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_sprite_blitter
// Sprite blit engine with view clipping and horizontal / vertical mirroring.
// A start transaction clips the sprite rectangle to the VIEW_COLS x VIEW_ROWS
// view and returns the first source and framebuffer addresses, or flags an
// empty blit. Each pixel transaction then brings the colors fetched at the
// last reported addresses and gets back the write address, the composed
// color (source when its alpha byte is nonzero, else destination) and the
// next addresses. The block takes one transaction per clock while the response
// side is not stalled. The input register loads at the accepting edge, then
// the clip register, then the response register, where the cursors advance.
// The start addresses use one 13x13 multiply for the source and one constant
// multiply for the framebuffer, both in the last stage. The user must write
// registers only while no transaction is in flight; the block itself does
// not enforce this, and a write may fall between the pixels of a running
// blit. src_stride and flip_mode are read live as the cursors step.
// ----------------------------------------------------------------------------
module clipped_sprite_blitter
   import csb_pkg::*;
#(
   parameter int VIEW_COLS     = 320,
   parameter int VIEW_ROWS     = 240,
   parameter int SRC_ADDR_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [COLOR_W-1:0]       req_src_color,
   input  logic [COLOR_W-1:0]       req_dst_color,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [SRC_ADDR_BITS-1:0] rsp_next_src_addr,
   output logic [DST_ADDR_W-1:0]    rsp_next_dst_addr,
   output logic                     rsp_write_valid,
   output logic [DST_ADDR_W-1:0]    rsp_write_addr,
   output logic [COLOR_W-1:0]       rsp_write_color,
   output logic                     rsp_last_pixel,
   output logic                     rsp_empty_blit
);

   localparam int SA         = SRC_ADDR_BITS;
   localparam int PROD_W     = COORD_W + STRIDE_W;
   localparam int DST_PROD_W = POS_U_W + VIEW_W;

   localparam logic signed [CLIP_W-1:0] VIEW_COLS_S = CLIP_W'(VIEW_COLS);
   localparam logic signed [CLIP_W-1:0] VIEW_ROWS_S = CLIP_W'(VIEW_ROWS);
   localparam logic signed [CLIP_W-1:0] ONE_S       = CLIP_W'(1);
   localparam logic [DST_ADDR_W-1:0]    DST_ROW_STEP = DST_ADDR_W'(VIEW_COLS + 1);
   localparam logic [DST_PROD_W-1:0]    VIEW_COLS_P  = DST_PROD_W'(VIEW_COLS);
   localparam logic [SA-1:0]            SRC_ONE      = SA'(1);

   // Clip results carried with a transaction into the last stage
   typedef struct packed {
      logic                opcode;
      logic [COLOR_W-1:0]  src_color;
      logic [COLOR_W-1:0]  dst_color;
      logic                empty;
      logic [SPAN_W-1:0]   span_cols;
      logic [SPAN_W-1:0]   span_rows;
      logic [POS_U_W-1:0]  sx;
      logic [POS_U_W-1:0]  sy;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
   } clip_type;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [POS_W-1:0] dest_x_ff, dest_y_ff;
   logic [SIZE_W-1:0]       sprite_width_ff, sprite_height_ff;
   logic [TEX_W-1:0]        tex_x_ff, tex_y_ff;
   logic [STRIDE_W-1:0]     src_stride_ff;
   logic [FLIP_W-1:0]       flip_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff        <= '0;
         dest_y_ff        <= '0;
         sprite_width_ff  <= SPRITE_SIZE_RST;
         sprite_height_ff <= SPRITE_SIZE_RST;
         tex_x_ff         <= '0;
         tex_y_ff         <= '0;
         src_stride_ff    <= SRC_STRIDE_RST;
         flip_mode_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEST_X:        dest_x_ff        <= csr_wdata[POS_W-1:0];
            REG_DEST_Y:        dest_y_ff        <= csr_wdata[POS_W-1:0];
            REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SPRITE_HEIGHT: sprite_height_ff <= csr_wdata[SIZE_W-1:0];
            REG_TEX_X:         tex_x_ff         <= csr_wdata[TEX_W-1:0];
            REG_TEX_Y:         tex_y_ff         <= csr_wdata[TEX_W-1:0];
            REG_SRC_STRIDE:    src_stride_ff    <= csr_wdata[STRIDE_W-1:0];
            REG_FLIP_MODE:     flip_mode_ff     <= csr_wdata[FLIP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_en, s2_en, s1_en, fire;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign fire      = out_en && s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_valid_ff  <= req_valid;
         if (s2_en)  s2_valid_ff  <= s1_valid_ff;
         if (out_en) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------
   logic               s1_opcode_ff;
   logic [COLOR_W-1:0] s1_src_color_ff, s1_dst_color_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_opcode_ff    <= req_opcode;
         s1_src_color_ff <= req_src_color;
         s1_dst_color_ff <= req_dst_color;
      end
   end

   // ---------------------------------------------------------------
   // Clip the sprite rectangle to the view
   // ---------------------------------------------------------------
   logic signed [CLIP_W-1:0] dx_s, dy_s, w_s, h_s, x_end_s, y_end_s;
   logic signed [CLIP_W-1:0] sx_s, sy_s, ex_s, ey_s, spx_s, spy_s;
   logic signed [CLIP_W-1:0] offx_s, offy_s, colx_s, rowy_s;
   clip_type                 s2_in, s2_ff;

   always_comb begin
      dx_s    = CLIP_W'(dest_x_ff);
      dy_s    = CLIP_W'(dest_y_ff);
      w_s     = $signed({{(CLIP_W-SIZE_W){1'b0}}, sprite_width_ff});
      h_s     = $signed({{(CLIP_W-SIZE_W){1'b0}}, sprite_height_ff});
      x_end_s = dx_s + w_s;
      y_end_s = dy_s + h_s;
      sx_s    = (dx_s > 0) ? dx_s : '0;
      sy_s    = (dy_s > 0) ? dy_s : '0;
      ex_s    = (x_end_s < VIEW_COLS_S) ? x_end_s : VIEW_COLS_S;
      ey_s    = (y_end_s < VIEW_ROWS_S) ? y_end_s : VIEW_ROWS_S;
      spx_s   = ex_s - sx_s;
      spy_s   = ey_s - sy_s;
      // sprite offset of the first visible pixel, mirrored if flipped
      offx_s  = sx_s - dx_s;
      offy_s  = sy_s - dy_s;
      colx_s  = flip_mode_ff[FLIP_H_BIT] ? (w_s - ONE_S - offx_s) : offx_s;
      rowy_s  = flip_mode_ff[FLIP_V_BIT] ? (h_s - ONE_S - offy_s) : offy_s;

      s2_in.opcode    = s1_opcode_ff;
      s2_in.src_color = s1_src_color_ff;
      s2_in.dst_color = s1_dst_color_ff;
      s2_in.empty     = (spx_s <= 0) || (spy_s <= 0);
      s2_in.span_cols = spx_s[SPAN_W-1:0];
      s2_in.span_rows = spy_s[SPAN_W-1:0];
      s2_in.sx        = sx_s[POS_U_W-1:0];
      s2_in.sy        = sy_s[POS_U_W-1:0];
      s2_in.col       = COORD_W'(colx_s[SIZE_W-1:0]) + COORD_W'(tex_x_ff);
      s2_in.row       = COORD_W'(rowy_s[SIZE_W-1:0]) + COORD_W'(tex_y_ff);
   end

   // Stage 2: clip register
   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: start addresses
   // ---------------------------------------------------------------
   logic [PROD_W-1:0]     src_prod;
   logic [PROD_W:0]       src_sum;
   logic [SA-1:0]         src_start;
   logic [DST_PROD_W-1:0] dst_prod;
   logic [DST_ADDR_W-1:0] dst_start;

   assign src_prod  = PROD_W'(s2_ff.row) * PROD_W'(src_stride_ff);
   assign src_sum   = (PROD_W+1)'(src_prod) + (PROD_W+1)'(s2_ff.col);
   assign src_start = SA'(src_sum);
   assign dst_prod  = DST_PROD_W'(s2_ff.sy) * VIEW_COLS_P;
   assign dst_start = DST_ADDR_W'(dst_prod + DST_PROD_W'(s2_ff.sx));

   // ---------------------------------------------------------------
   // Stage 3: cursor state and response
   // ---------------------------------------------------------------
   logic [SPAN_W-1:0]     col_count_ff, col_count_in;
   logic [SPAN_W-1:0]     row_count_ff, row_count_in;
   logic [SPAN_W-1:0]     span_cols_ff, span_cols_in;
   logic [SPAN_W-1:0]     span_rows_ff, span_rows_in;
   logic [DST_ADDR_W-1:0] dst_cursor_ff, dst_cursor_in;
   logic [SA-1:0]         src_cursor_ff, src_cursor_in;
   logic [SA-1:0]         src_row_start_ff, src_row_start_in;
   logic                  busy_ff, busy_in;

   logic [SA-1:0]         rsp_next_src_ff, rsp_next_src_in;
   logic [DST_ADDR_W-1:0] rsp_next_dst_ff, rsp_next_dst_in;
   logic                  rsp_write_valid_ff, rsp_write_valid_in;
   logic [DST_ADDR_W-1:0] rsp_write_addr_ff, rsp_write_addr_in;
   logic [COLOR_W-1:0]    rsp_write_color_ff, rsp_write_color_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic [SPAN_W:0]       col_inc, row_inc;
   logic                  more_cols, last_row;
   logic [SA-1:0]         stride_ext, src_row_next;

   always_comb begin
      col_inc      = {1'b0, col_count_ff} + 1'b1;
      row_inc      = {1'b0, row_count_ff} + 1'b1;
      more_cols    = col_inc < {1'b0, span_cols_ff};
      last_row     = row_inc >= {1'b0, span_rows_ff};
      stride_ext   = SA'(src_stride_ff);
      src_row_next = flip_mode_ff[FLIP_V_BIT] ? (src_row_start_ff - stride_ext)
                                              : (src_row_start_ff + stride_ext);

      // hold by default
      col_count_in     = col_count_ff;
      row_count_in     = row_count_ff;
      span_cols_in     = span_cols_ff;
      span_rows_in     = span_rows_ff;
      dst_cursor_in    = dst_cursor_ff;
      src_cursor_in    = src_cursor_ff;
      src_row_start_in = src_row_start_ff;
      busy_in          = busy_ff;

      rsp_next_src_in    = src_cursor_ff;
      rsp_next_dst_in    = dst_cursor_ff;
      rsp_write_valid_in = 1'b0;
      rsp_write_addr_in  = '0;
      rsp_write_color_in = '0;
      rsp_last_in        = 1'b0;
      rsp_empty_in       = 1'b0;

      if (s2_ff.opcode == OP_START) begin
         col_count_in = '0;
         row_count_in = '0;
         if (s2_ff.empty) begin
            busy_in          = 1'b0;
            span_cols_in     = '0;
            span_rows_in     = '0;
            dst_cursor_in    = '0;
            src_cursor_in    = '0;
            src_row_start_in = '0;
            rsp_next_src_in  = '0;
            rsp_next_dst_in  = '0;
            rsp_empty_in     = 1'b1;
         end else begin
            busy_in          = 1'b1;
            span_cols_in     = s2_ff.span_cols;
            span_rows_in     = s2_ff.span_rows;
            dst_cursor_in    = dst_start;
            src_cursor_in    = src_start;
            src_row_start_in = src_start;
            rsp_next_src_in  = src_start;
            rsp_next_dst_in  = dst_start;
         end
      end else if (busy_ff) begin
         rsp_write_valid_in = 1'b1;
         rsp_write_addr_in  = dst_cursor_ff;
         rsp_write_color_in = ((s2_ff.src_color & ALPHA_MASK) != '0) ? s2_ff.src_color
                                                                    : s2_ff.dst_color;
         if (more_cols) begin
            // step along the row
            col_count_in  = col_inc[SPAN_W-1:0];
            src_cursor_in = flip_mode_ff[FLIP_H_BIT] ? (src_cursor_ff - SRC_ONE)
                                                     : (src_cursor_ff + SRC_ONE);
            dst_cursor_in = dst_cursor_ff + 1'b1;
         end else if (last_row) begin
            // final pixel of the blit
            col_count_in = '0;
            row_count_in = '0;
            busy_in      = 1'b0;
            rsp_last_in  = 1'b1;
         end else begin
            // wrap to the next row
            col_count_in     = '0;
            row_count_in     = row_inc[SPAN_W-1:0];
            src_row_start_in = src_row_next;
            src_cursor_in    = src_row_next;
            dst_cursor_in    = dst_cursor_ff + DST_ROW_STEP - DST_ADDR_W'(span_cols_ff);
         end
         rsp_next_src_in = rsp_last_in ? '0 : src_cursor_in;
         rsp_next_dst_in = rsp_last_in ? '0 : dst_cursor_in;
      end
   end

   // Cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff     <= '0;
         row_count_ff     <= '0;
         span_cols_ff     <= '0;
         span_rows_ff     <= '0;
         dst_cursor_ff    <= '0;
         src_cursor_ff    <= '0;
         src_row_start_ff <= '0;
         busy_ff          <= 1'b0;
      end else if (fire) begin
         col_count_ff     <= col_count_in;
         row_count_ff     <= row_count_in;
         span_cols_ff     <= span_cols_in;
         span_rows_ff     <= span_rows_in;
         dst_cursor_ff    <= dst_cursor_in;
         src_cursor_ff    <= src_cursor_in;
         src_row_start_ff <= src_row_start_in;
         busy_ff          <= busy_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_next_src_ff    <= rsp_next_src_in;
         rsp_next_dst_ff    <= rsp_next_dst_in;
         rsp_write_valid_ff <= rsp_write_valid_in;
         rsp_write_addr_ff  <= rsp_write_addr_in;
         rsp_write_color_ff <= rsp_write_color_in;
         rsp_last_ff        <= rsp_last_in;
         rsp_empty_ff       <= rsp_empty_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_src_addr = rsp_next_src_ff;
   assign rsp_next_dst_addr = rsp_next_dst_ff;
   assign rsp_write_valid   = rsp_write_valid_ff;
   assign rsp_write_addr    = rsp_write_addr_ff;
   assign rsp_write_color   = rsp_write_color_ff;
   assign rsp_last_pixel    = rsp_last_ff;
   assign rsp_empty_blit    = rsp_empty_ff;

endmodule

FILE: rtl/core/csb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks on the blitter's responses, bound into each blitter instance.
// ----------------------------------------------------------------------------
`include "clipped_sprite_blitter_macros.svh"

module csb_checker
   import csb_pkg::*;
#(
   parameter int SRC_ADDR_BITS = 24
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [SRC_ADDR_BITS-1:0] rsp_next_src_addr,
   input logic [DST_ADDR_W-1:0]    rsp_next_dst_addr,
   input logic                     rsp_write_valid,
   input logic [DST_ADDR_W-1:0]    rsp_write_addr,
   input logic [COLOR_W-1:0]       rsp_write_color,
   input logic                     rsp_last_pixel,
   input logic                     rsp_empty_blit
);

   // Last pixel writes and clears both fetch addresses
   `CSB_ASSERT_IMPLY(a_last_pixel, clock, reset, rsp_valid && rsp_last_pixel, rsp_write_valid && !rsp_empty_blit && rsp_next_src_addr == '0 && rsp_next_dst_addr == '0, "last pixel without write or with live addresses")

   // Empty blit writes nothing and reports zero addresses
   `CSB_ASSERT_IMPLY(a_empty_blit, clock, reset, rsp_valid && rsp_empty_blit, !rsp_write_valid && rsp_next_src_addr == '0 && rsp_next_dst_addr == '0, "empty blit with write or live addresses")

   // No write means quiet write fields
   `CSB_ASSERT_IMPLY(a_no_write, clock, reset, rsp_valid && !rsp_write_valid, rsp_write_addr == '0 && rsp_write_color == '0 && !rsp_last_pixel, "write fields set without write")

   // A stalled response holds
   `CSB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_addr) && $stable(rsp_write_color) && $stable(rsp_next_src_addr), "stalled response changed")

endmodule

bind clipped_sprite_blitter csb_checker #(.SRC_ADDR_BITS(SRC_ADDR_BITS)) u_csb_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped sprite blitter. A short table of hand
// picked transactions (idle pixels, abandoned blits, left, right, bottom and
// zero-size empty clips, mirrored and wrapped addresses, flip and stride
// changed mid-blit) is followed by random phases of register settings and
// blits. Every response is checked field by field against a typed value or
// an in-bench clip and cursor model, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb;
   import csb_pkg::*;

   localparam int VIEW_COLS     = 320;
   localparam int VIEW_ROWS     = 240;
   localparam int SRC_BITS      = 24;
   localparam int DRAIN_CYCLES  = 6;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [SRC_BITS-1:0]   next_src_addr;
      logic [DST_ADDR_W-1:0] next_dst_addr;
      logic                  write_valid;
      logic [DST_ADDR_W-1:0] write_addr;
      logic [COLOR_W-1:0]    write_color;
      logic                  last_pixel;
      logic                  empty_blit;
   } blit_rsp_t;

   typedef enum {ROW_REG, ROW_ITEM} row_kind_t;

   typedef struct {
      row_kind_t           kind;
      csr_index_type       reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      opcode_type          op;
      logic [COLOR_W-1:0]  src_color;
      logic [COLOR_W-1:0]  dst_color;
      bit                  typed;
      blit_rsp_t           want;
   } stim_row_t;

   localparam blit_rsp_t NO_RSP    = '0;
   localparam blit_rsp_t EMPTY_RSP = '{24'd0, 17'd0, 1'b0, 17'd0, 32'd0, 1'b0, 1'b1};

   // Clock and DUT ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_opcode = 1'b0;
   logic [COLOR_W-1:0]       req_src_color = '0;
   logic [COLOR_W-1:0]       req_dst_color = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [SRC_BITS-1:0]      rsp_next_src_addr;
   logic [DST_ADDR_W-1:0]    rsp_next_dst_addr;
   logic                     rsp_write_valid;
   logic [DST_ADDR_W-1:0]    rsp_write_addr;
   logic [COLOR_W-1:0]       rsp_write_color;
   logic                     rsp_last_pixel;
   logic                     rsp_empty_blit;

   // Register copy, reset values
   logic [POS_W-1:0]    cfg_dest_x = '0;
   logic [POS_W-1:0]    cfg_dest_y = '0;
   logic [SIZE_W-1:0]   cfg_width  = SPRITE_SIZE_RST;
   logic [SIZE_W-1:0]   cfg_height = SPRITE_SIZE_RST;
   logic [TEX_W-1:0]    cfg_tex_x  = '0;
   logic [TEX_W-1:0]    cfg_tex_y  = '0;
   logic [STRIDE_W-1:0] cfg_stride = SRC_STRIDE_RST;
   logic [FLIP_W-1:0]   cfg_flip   = '0;

   // Blit cursor state
   int unsigned           col_idx = 0, row_idx = 0, cols_span = 0, rows_span = 0;
   logic [DST_ADDR_W-1:0] dst_ptr = '0;
   logic [SRC_BITS-1:0]   src_ptr = '0, src_line = '0;
   bit                    blit_busy = 1'b0;

   blit_rsp_t awaited_rsp[$];
   stim_row_t directed_rows[$];
   int        fault_count = 0;
   int        fed_items = 0;
   int        cycle_count = 0;
   bit        settled = 1'b1;
   bit        req_gaps_on = 1'b1;
   bit        rsp_gaps_on = 1'b1;

   clipped_sprite_blitter #(
      .VIEW_COLS     (VIEW_COLS),
      .VIEW_ROWS     (VIEW_ROWS),
      .SRC_ADDR_BITS (SRC_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_src_color     (req_src_color),
      .req_dst_color     (req_dst_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_src_addr (rsp_next_src_addr),
      .rsp_next_dst_addr (rsp_next_dst_addr),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_addr    (rsp_write_addr),
      .rsp_write_color   (rsp_write_color),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_empty_blit    (rsp_empty_blit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clip a start against the view, or step the cursors for one pixel
   function automatic void blit_step(input opcode_type op, input logic [COLOR_W-1:0] sc,
                                     input logic [COLOR_W-1:0] dc, output blit_rsp_t r);
      int     dx, dy, w, h, sx, sy, ex, ey, spx, spy;
      longint col, row;
      r = '0;
      if (op == OP_START) begin
         dx = int'($signed(cfg_dest_x));
         dy = int'($signed(cfg_dest_y));
         w  = int'(cfg_width);
         h  = int'(cfg_height);
         sx = (dx > 0) ? dx : 0;
         sy = (dy > 0) ? dy : 0;
         ex = (dx + w < VIEW_COLS) ? dx + w : VIEW_COLS;
         ey = (dy + h < VIEW_ROWS) ? dy + h : VIEW_ROWS;
         spx = ex - sx;
         spy = ey - sy;
         col_idx = 0;
         row_idx = 0;
         if (spx <= 0 || spy <= 0) begin
            blit_busy = 1'b0;
            cols_span = 0;
            rows_span = 0;
            dst_ptr   = '0;
            src_ptr   = '0;
            src_line  = '0;
            r.empty_blit = 1'b1;
            return;
         end
         cols_span = spx;
         rows_span = spy;
         // mirrored start is the far edge minus the clipped amount
         col = cfg_flip[FLIP_H_BIT] ? longint'(w - 1 - (sx - dx)) : longint'(sx - dx);
         row = cfg_flip[FLIP_V_BIT] ? longint'(h - 1 - (sy - dy)) : longint'(sy - dy);
         col += longint'(cfg_tex_x);
         row += longint'(cfg_tex_y);
         src_line  = SRC_BITS'(col + row * longint'(cfg_stride));
         src_ptr   = src_line;
         dst_ptr   = DST_ADDR_W'(sx + sy * VIEW_COLS);
         blit_busy = 1'b1;
         r.next_src_addr = src_ptr;
         r.next_dst_addr = dst_ptr;
         return;
      end
      // pixel while idle: cursors are only echoed
      if (!blit_busy) begin
         r.next_src_addr = src_ptr;
         r.next_dst_addr = dst_ptr;
         return;
      end
      r.write_valid = 1'b1;
      r.write_addr  = dst_ptr;
      r.write_color = ((sc & ALPHA_MASK) != '0) ? sc : dc;
      if (col_idx + 1 < cols_span) begin
         col_idx++;
         src_ptr = cfg_flip[FLIP_H_BIT] ? src_ptr - 1'b1 : src_ptr + 1'b1;
         dst_ptr = dst_ptr + 1'b1;
         r.next_src_addr = src_ptr;
         r.next_dst_addr = dst_ptr;
         return;
      end
      col_idx = 0;
      if (row_idx + 1 >= rows_span) begin
         row_idx   = 0;
         blit_busy = 1'b0;
         r.last_pixel = 1'b1;
         return;
      end
      // next row; stride and flip are taken as they stand now
      row_idx++;
      src_line = cfg_flip[FLIP_V_BIT] ? src_line - cfg_stride : src_line + cfg_stride;
      src_ptr  = src_line;
      dst_ptr  = DST_ADDR_W'(int'(dst_ptr) + 1 - int'(cols_span) + VIEW_COLS);
      r.next_src_addr = src_ptr;
      r.next_dst_addr = dst_ptr;
   endfunction

   function automatic int draw_gap(input bit on);
      return on ? int'($urandom_range(0, 16)) : 0;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_src_color();
      logic [COLOR_W-1:0] c;
      c = $urandom;
      case ($urandom_range(0, 4))
         0, 1: c[31:24] = 8'h00;
         2: c[31:24] = 8'(1 << $urandom_range(0, 7));
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_reg(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] v;
      int roll, view;
      roll = $urandom_range(0, 7);
      view = (idx == REG_DEST_X) ? VIEW_COLS : VIEW_ROWS;
      v = '0;
      case (idx)
         REG_DEST_X, REG_DEST_Y: begin
            case (roll)
               0: v = {1'b0, 12'($urandom_range(0, 4095))};
               1: v = {1'b0, 12'(view - 8 + int'($urandom_range(0, 15)))};
               2: v = {1'b0, 12'(0 - int'($urandom_range(0, 16)))};
               default: v = {1'b0, 12'($urandom_range(0, view - 8))};
            endcase
         end
         REG_SPRITE_WIDTH, REG_SPRITE_HEIGHT: begin
            v = (roll == 0) ? 13'($urandom_range(0, 1023)) :
                (roll == 1) ? 13'd0 : 13'($urandom_range(1, 10));
         end
         REG_TEX_X, REG_TEX_Y: begin
            v = (roll == 0) ? 13'd0 : (roll == 1) ? 13'd4095 : 13'($urandom_range(0, 4095));
         end
         REG_SRC_STRIDE: begin
            case (roll)
               0: v = 13'($urandom_range(0, 8191));
               1: v = 13'd1;
               2: v = 13'd4096;
               default: v = 13'($urandom_range(1, 640));
            endcase
         end
         REG_FLIP_MODE: v = 13'($urandom_range(0, 3));
      endcase
      return v;
   endfunction

   function automatic stim_row_t reg_row(input csr_index_type idx, input logic [12:0] val);
      stim_row_t row;
      row = '{ROW_REG, idx, val, OP_START, '0, '0, 1'b0, NO_RSP};
      return row;
   endfunction

   function automatic stim_row_t item_row(input opcode_type op, input logic [31:0] sc,
                                          input logic [31:0] dc);
      stim_row_t row;
      row = '{ROW_ITEM, REG_DEST_X, '0, op, sc, dc, 1'b0, NO_RSP};
      return row;
   endfunction

   function automatic stim_row_t typed_row(input opcode_type op, input logic [31:0] sc,
                                           input logic [31:0] dc, input blit_rsp_t want);
      stim_row_t row;
      row = '{ROW_ITEM, REG_DEST_X, '0, op, sc, dc, 1'b1, want};
      return row;
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // Register write, only once every response is back and the pipe is quiet
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      if (!settled) begin
         req_valid <= 1'b0;
         while (awaited_rsp.size() != 0) @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
         settled = 1'b1;
      end
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_DEST_X:        cfg_dest_x = val[POS_W-1:0];
         REG_DEST_Y:        cfg_dest_y = val[POS_W-1:0];
         REG_SPRITE_WIDTH:  cfg_width  = val[SIZE_W-1:0];
         REG_SPRITE_HEIGHT: cfg_height = val[SIZE_W-1:0];
         REG_TEX_X:         cfg_tex_x  = val[TEX_W-1:0];
         REG_TEX_Y:         cfg_tex_y  = val[TEX_W-1:0];
         REG_SRC_STRIDE:    cfg_stride = val[STRIDE_W-1:0];
         REG_FLIP_MODE:     cfg_flip   = val[FLIP_W-1:0];
      endcase
      @(negedge clock);
   endtask

   // Drive one request transaction and record the response it should get
   task automatic send_item(input opcode_type op, input logic [COLOR_W-1:0] sc,
                            input logic [COLOR_W-1:0] dc, input bit typed,
                            input blit_rsp_t want);
      int        gap;
      blit_rsp_t got;
      gap = draw_gap(req_gaps_on);
      csr_wr_en <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_src_color <= sc;
      req_dst_color <= dc;
      do @(posedge clock); while (!req_ready);
      if (op == OP_START || blit_busy) fed_items++;
      blit_step(op, sc, dc, got);
      awaited_rsp.push_back(typed ? want : got);
      settled = 1'b0;
      @(negedge clock);
   endtask

   // Response side: random stalls, with quiet stretches
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(rsp_gaps_on);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      blit_rsp_t seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_next_src_addr, rsp_next_dst_addr, rsp_write_valid, rsp_write_addr,
                  rsp_write_color, rsp_last_pixel, rsp_empty_blit};
         if (awaited_rsp.size() == 0) begin
            log_fault($sformatf("unexpected response transaction at cycle %0d", cycle_count));
         end else begin
            want = awaited_rsp.pop_front();
            if (seen.next_src_addr !== want.next_src_addr ||
                seen.next_dst_addr !== want.next_dst_addr ||
                seen.write_valid   !== want.write_valid   ||
                seen.write_addr    !== want.write_addr    ||
                seen.write_color   !== want.write_color   ||
                seen.last_pixel    !== want.last_pixel    ||
                seen.empty_blit    !== want.empty_blit)
               log_fault($sformatf({"mismatch at cycle %0d (exp/got): nsrc %h/%h ndst %h/%h ",
                  "wv %b/%b waddr %h/%h wcol %h/%h last %b/%b empty %b/%b"}, cycle_count,
                  want.next_src_addr, seen.next_src_addr, want.next_dst_addr,
                  seen.next_dst_addr, want.write_valid, seen.write_valid, want.write_addr,
                  seen.write_addr, want.write_color, seen.write_color, want.last_pixel,
                  seen.last_pixel, want.empty_blit, seen.empty_blit));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[clipped_sprite_blitter] ERROR");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int blits, area, npix;
      opcode_type op;

      // idle pixels, abandoned blit, 1x1 blit, empty clips
      directed_rows.push_back(typed_row(OP_PIXEL, 32'hffff_ffff, 32'hffff_ffff, NO_RSP));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, NO_RSP));
      directed_rows.push_back(typed_row(OP_PIXEL, 32'hff00_0000, 32'h0,
         '{24'd1, 17'd1, 1'b1, 17'd0, 32'hff00_0000, 1'b0, 1'b0}));
      directed_rows.push_back(typed_row(OP_PIXEL, 32'h00ff_ffff, 32'h1234_5678,
         '{24'd2, 17'd2, 1'b1, 17'd1, 32'h1234_5678, 1'b0, 1'b0}));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, NO_RSP));
      directed_rows.push_back(reg_row(REG_SPRITE_WIDTH, 13'd1));
      directed_rows.push_back(reg_row(REG_SPRITE_HEIGHT, 13'd1));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, NO_RSP));
      directed_rows.push_back(typed_row(OP_PIXEL, 32'h8000_0000, 32'h0,
         '{24'd0, 17'd0, 1'b1, 17'd0, 32'h8000_0000, 1'b1, 1'b0}));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h0, 32'hffff_ffff));
      directed_rows.push_back(reg_row(REG_DEST_X, 13'h0800));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, EMPTY_RSP));
      directed_rows.push_back(reg_row(REG_DEST_X, 13'h07ff));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, EMPTY_RSP));
      directed_rows.push_back(reg_row(REG_DEST_X, 13'h0000));
      directed_rows.push_back(reg_row(REG_DEST_Y, 13'h07ff));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, EMPTY_RSP));
      directed_rows.push_back(reg_row(REG_DEST_Y, 13'h0000));
      directed_rows.push_back(reg_row(REG_SPRITE_WIDTH, 13'd0));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, EMPTY_RSP));
      directed_rows.push_back(reg_row(REG_SPRITE_WIDTH, 13'd1023));
      directed_rows.push_back(reg_row(REG_SPRITE_HEIGHT, 13'd0));
      directed_rows.push_back(typed_row(OP_START, 32'h0, 32'h0, EMPTY_RSP));
      // clipped on top and left, both mirrors, texture and stride at their tops
      directed_rows.push_back(reg_row(REG_DEST_X, 13'h0ffd));
      directed_rows.push_back(reg_row(REG_DEST_Y, 13'h0ffe));
      directed_rows.push_back(reg_row(REG_SPRITE_WIDTH, 13'd5));
      directed_rows.push_back(reg_row(REG_SPRITE_HEIGHT, 13'd4));
      directed_rows.push_back(reg_row(REG_TEX_X, 13'd4095));
      directed_rows.push_back(reg_row(REG_TEX_Y, 13'd4095));
      directed_rows.push_back(reg_row(REG_SRC_STRIDE, 13'd8191));
      directed_rows.push_back(reg_row(REG_FLIP_MODE, 13'd3));
      directed_rows.push_back(item_row(OP_START, 32'h0, 32'h0));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h0100_0001, 32'hdead_beef));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h00ab_cdef, 32'h5555_aaaa));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h7fff_ffff, 32'h0));
      // flip and stride change while the blit is still running
      directed_rows.push_back(reg_row(REG_FLIP_MODE, 13'd0));
      directed_rows.push_back(reg_row(REG_SRC_STRIDE, 13'd1));
      directed_rows.push_back(item_row(OP_PIXEL, 32'hffff_ffff, 32'h0));
      // clipped on bottom and right
      directed_rows.push_back(reg_row(REG_DEST_X, 13'd318));
      directed_rows.push_back(reg_row(REG_DEST_Y, 13'd238));
      directed_rows.push_back(reg_row(REG_SPRITE_WIDTH, 13'd1023));
      directed_rows.push_back(reg_row(REG_SPRITE_HEIGHT, 13'd1023));
      directed_rows.push_back(reg_row(REG_TEX_X, 13'd0));
      directed_rows.push_back(reg_row(REG_TEX_Y, 13'd0));
      directed_rows.push_back(reg_row(REG_SRC_STRIDE, 13'd4096));
      directed_rows.push_back(reg_row(REG_FLIP_MODE, 13'd1));
      directed_rows.push_back(item_row(OP_START, 32'h0, 32'h0));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h0000_0000, 32'hffff_ffff));
      directed_rows.push_back(item_row(OP_PIXEL, 32'hff00_0000, 32'h0));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h00ff_ffff, 32'h0f0f_0f0f));
      directed_rows.push_back(item_row(OP_PIXEL, 32'h8123_4567, 32'h0));
      directed_rows.push_back(item_row(OP_PIXEL, 32'hffff_ffff, 32'h0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG)
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         else
            send_item(directed_rows[i].op, directed_rows[i].src_color,
                      directed_rows[i].dst_color, directed_rows[i].typed,
                      directed_rows[i].want);
      end

      // random phases: new settings, then a few blits
      fed_items = 0;
      while (fed_items < RANDOM_ITEMS) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         for (int r = 0; r < 8; r++)
            write_reg(csr_index_type'(r), pick_reg(csr_index_type'(r)));
         blits = $urandom_range(1, 4);
         repeat (blits) begin
            send_item(OP_START, pick_src_color(), $urandom, 1'b0, NO_RSP);
            area = int'(cols_span * rows_span);
            npix = (area == 0) ? int'($urandom_range(0, 2)) :
                   (area <= 128) ? area : int'($urandom_range(1, 40));
            // cut some blits short, run past the end of others
            if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, npix);
            if ($urandom_range(0, 9) == 0) npix += $urandom_range(1, 2);
            repeat (npix) begin
               op = ($urandom_range(0, 15) == 0) ? opcode_type'($urandom_range(0, 1)) : OP_PIXEL;
               send_item(op, pick_src_color(), $urandom, 1'b0, NO_RSP);
            end
         end
      end

      // drain
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (fault_count == 0)
         $display("[clipped_sprite_blitter] OK");
      else
         $display("[clipped_sprite_blitter] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/csb_pkg.sv
rtl/core/clipped_sprite_blitter.sv
rtl/core/csb_checker.sv
tb/sv/tb.sv
